[sv/ntwr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntwr_pkg
// Shared widths, register indexes and item types of the nearest-three search.
// ----------------------------------------------------------------------------
package ntwr_pkg;

  localparam int ID_W        = 32;
  localparam int COORD_W     = 24;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int SQ_W        = 2 * DIFF_W;
  localparam int DIST_W      = 52;
  localparam int CNT_W       = 2;
  localparam int OUT_SLOTS   = 3;
  localparam int KEEP_COUNT_DEF = 3;

  localparam int IN_DATA_W   = 104;
  localparam int OUT_DATA_W  = 104;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = DIST_W;

  localparam logic [DIST_W-1:0] RADIUS_SQ_RST = DIST_W'(256000000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X  = 2'd0,
    CFG_CENTER_Y  = 2'd1,
    CFG_CENTER_Z  = 2'd2,
    CFG_RADIUS_SQ = 2'd3
  } cfg_idx_t;

  // Candidate as it leaves the distance pipeline.
  typedef struct packed {
    logic              valid;
    logic              last;
    logic              ok;
    logic [ID_W-1:0]   entity;
    logic [DIST_W-1:0] distance;
  } cand_t;

  // Contents of one slot of the sorted chain.
  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   entity;
    logic [DIST_W-1:0] distance;
  } slot_t;

endpackage : ntwr_pkg
`default_nettype wire

[sv/nearest_three_within_radius.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_three_within_radius
// Keeps the nearest candidates within a squared radius and reports three ids.
// ----------------------------------------------------------------------------
//  channel | dir | contents
//  in_     | in  | tdata: entity, pos_x, pos_y, pos_z; tuser: is_primary; tlast
//  out_    | out | tdata: nearest_first, nearest_second, nearest_third, found_count
//  cfg_    | in  | cfg_index selects center_x/y/z or radius_sq, cfg_data value
//
// One item per cycle while in_tready is high. An item passes the difference,
// square and sum/compare stages and is then written into the slot chain; for a
// last item the same edge loads the result and raises out_tvalid.
// A last item waits in front of the chain while the output register holds a
// result that is not taken in that cycle, which stalls the whole pipeline and
// drops in_tready.
// Reset clears the slots, primary id and valid flags and returns the config registers to their defaults.
// ----------------------------------------------------------------------------
module nearest_three_within_radius
  import ntwr_pkg::*;
#(
  parameter int KEEP_COUNT = KEEP_COUNT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // entity, pos_x, pos_y, pos_z
  input  wire logic                  in_tuser,   // is_primary
  input  wire logic                  in_tlast,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // first, second, third, found_count
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic signed [COORD_W-1:0] center_x_r, center_y_r, center_z_r;
  logic [DIST_W-1:0]         radius_sq_r;
  logic                      adv, acc, fire;
  cand_t                     cand;
  logic [KEEP_COUNT:0]       keep_chain;
  slot_t                     slot_chain [KEEP_COUNT+1];
  slot_t                     slot_upd   [KEEP_COUNT];
  logic [ID_W-1:0]           res_ent    [OUT_SLOTS];
  logic [OUT_SLOTS-1:0]      res_vld;
  logic [CNT_W-1:0]          res_cnt;
  logic                      out_valid_r;
  logic [OUT_DATA_W-1:0]     out_data_r;

  assign adv       = !(cand.valid && cand.last && out_valid_r && !out_tready);
  assign in_tready = adv;
  assign acc       = in_tvalid && adv;
  assign fire      = adv && cand.valid;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r  <= '0;
      center_y_r  <= '0;
      center_z_r  <= '0;
      radius_sq_r <= RADIUS_SQ_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CENTER_X:  center_x_r  <= cfg_data[COORD_W-1:0];
        CFG_CENTER_Y:  center_y_r  <= cfg_data[COORD_W-1:0];
        CFG_CENTER_Z:  center_z_r  <= cfg_data[COORD_W-1:0];
        CFG_RADIUS_SQ: radius_sq_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ntwr_dist u_dist (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .acc        (acc),
    .entity     (in_tdata[ID_W-1:0]),
    .pos_x      (in_tdata[ID_W+COORD_W-1:ID_W]),
    .pos_y      (in_tdata[ID_W+2*COORD_W-1:ID_W+COORD_W]),
    .pos_z      (in_tdata[ID_W+3*COORD_W-1:ID_W+2*COORD_W]),
    .is_primary (in_tuser),
    .last       (in_tlast),
    .center_x   (center_x_r),
    .center_y   (center_y_r),
    .center_z   (center_z_r),
    .radius_sq  (radius_sq_r),
    .cand       (cand)
  );

  // The head of the chain always lets the candidate in behind it.
  assign keep_chain[0] = 1'b1;
  assign slot_chain[0] = '0;

  for (genvar i = 0; i < KEEP_COUNT; i++) begin : g_cell
    ntwr_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .fire     (fire),
      .cand     (cand),
      .up_keep  (keep_chain[i]),
      .up_slot  (slot_chain[i]),
      .keep     (keep_chain[i+1]),
      .slot     (slot_chain[i+1]),
      .slot_upd (slot_upd[i])
    );
  end

  for (genvar j = 0; j < OUT_SLOTS; j++) begin : g_res
    if (j < KEEP_COUNT) begin : g_on
      assign res_vld[j] = slot_upd[j].valid;
      assign res_ent[j] = slot_upd[j].valid ? slot_upd[j].entity : '0;
    end else begin : g_off
      assign res_vld[j] = 1'b0;
      assign res_ent[j] = '0;
    end
  end

  // Filled slots are packed from the front, so the count saturates at three.
  assign res_cnt = res_vld[2] ? CNT_W'(3) : res_vld[1] ? CNT_W'(2) :
                   res_vld[0] ? CNT_W'(1) : CNT_W'(0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && cand.last) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && cand.last) begin
      out_data_r <= OUT_DATA_W'({res_cnt, res_ent[2], res_ent[1], res_ent[0]});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule : nearest_three_within_radius
`default_nettype wire

[sv/ntwr_dist.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntwr_dist
// Primary tracking and a three-stage squared-distance pipeline with radius check.
// ----------------------------------------------------------------------------
module ntwr_dist
  import ntwr_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      adv,
  input  wire logic                      acc,
  input  wire logic [ID_W-1:0]           entity,
  input  wire logic signed [COORD_W-1:0] pos_x,
  input  wire logic signed [COORD_W-1:0] pos_y,
  input  wire logic signed [COORD_W-1:0] pos_z,
  input  wire logic                      is_primary,
  input  wire logic                      last,
  input  wire logic signed [COORD_W-1:0] center_x,
  input  wire logic signed [COORD_W-1:0] center_y,
  input  wire logic signed [COORD_W-1:0] center_z,
  input  wire logic [DIST_W-1:0]         radius_sq,
  output cand_t                          cand
);

  logic [ID_W-1:0]          primary_r, primary_nxt;
  logic                     take;

  // Stage 1: differences.
  logic                     v1_r, last1_r, take1_r;
  logic [ID_W-1:0]          ent1_r;
  logic signed [DIFF_W-1:0] dx1_r, dy1_r, dz1_r;
  // Stage 2: squares.
  logic                     v2_r, last2_r, take2_r;
  logic [ID_W-1:0]          ent2_r;
  logic [SQ_W-1:0]          sx2_r, sy2_r, sz2_r;
  logic [DIFF_W-1:0]        mx, my, mz;
  // Stage 3: sum and radius compare.
  cand_t                    c3_r;
  logic [DIST_W-1:0]        sum;

  always_comb begin
    take        = (entity != '0) && (is_primary || (entity != primary_r));
    primary_nxt = primary_r;
    if (last) begin
      primary_nxt = '0;
    end else if (is_primary) begin
      primary_nxt = entity;
    end
  end

  assign mx = dx1_r[DIFF_W-1] ? DIFF_W'(-dx1_r) : DIFF_W'(dx1_r);
  assign my = dy1_r[DIFF_W-1] ? DIFF_W'(-dy1_r) : DIFF_W'(dy1_r);
  assign mz = dz1_r[DIFF_W-1] ? DIFF_W'(-dz1_r) : DIFF_W'(dz1_r);

  assign sum = DIST_W'(sx2_r) + DIST_W'(sy2_r) + DIST_W'(sz2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primary_r <= '0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      c3_r      <= '0;
    end else begin
      if (acc) begin
        primary_r <= primary_nxt;
      end
      if (adv) begin
        v1_r       <= acc;
        v2_r       <= v1_r;
        c3_r.valid <= v2_r;
        c3_r.last  <= last2_r;
        c3_r.ok    <= take2_r && (sum <= radius_sq);
        c3_r.entity <= ent2_r;
        c3_r.distance <= sum;
      end
    end
  end

  // Payload stages carry no reset.
  always_ff @(posedge clk) begin
    if (adv) begin
      last1_r <= last;
      take1_r <= take;
      ent1_r  <= entity;
      dx1_r   <= DIFF_W'(pos_x) - DIFF_W'(center_x);
      dy1_r   <= DIFF_W'(pos_y) - DIFF_W'(center_y);
      dz1_r   <= DIFF_W'(pos_z) - DIFF_W'(center_z);
      last2_r <= last1_r;
      take2_r <= take1_r;
      ent2_r  <= ent1_r;
      sx2_r   <= mx * mx;
      sy2_r   <= my * my;
      sz2_r   <= mz * mz;
    end
  end

  assign cand = c3_r;

endmodule : ntwr_dist
`default_nettype wire

[sv/ntwr_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntwr_cell
// One slot of the sorted chain: keeps, takes the candidate, or takes its
// upstream neighbor's old contents; a last item clears it.
// ----------------------------------------------------------------------------
module ntwr_cell
  import ntwr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  fire,
  input  wire cand_t cand,
  input  wire logic  up_keep,
  input  wire slot_t up_slot,
  output logic       keep,
  output slot_t      slot,
  output slot_t      slot_upd
);

  slot_t slot_r, slot_nxt;

  // Slots stay sorted and packed, so a cell holds when its entry is no farther
  // than the candidate; ties keep the earlier arrival in front.
  assign keep = slot_r.valid && (slot_r.distance <= cand.distance);

  always_comb begin
    slot_upd = slot_r;
    if (cand.ok && !keep) begin
      if (up_keep) begin
        slot_upd.valid    = 1'b1;
        slot_upd.entity   = cand.entity;
        slot_upd.distance = cand.distance;
      end else begin
        slot_upd = up_slot;
      end
    end
    slot_nxt = cand.last ? '0 : slot_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else if (fire) begin
      slot_r <= slot_nxt;
    end
  end

  assign slot = slot_r;

endmodule : ntwr_cell
`default_nettype wire

[sv/ntwr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntwr_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ntwr_checker
  import ntwr_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result item dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result item changed while stalled");

  // Empty slots read as zero ids.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[97:96] == 2'd0) |-> (out_tdata[95:0] == '0))
    else $error("ids present with zero count");

  a_third: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[97:96] != 2'd3) |-> (out_tdata[95:64] == '0))
    else $error("third id present with count below three");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule : ntwr_checker

bind nearest_three_within_radius ntwr_checker u_ntwr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
